>>> sv/owrjf_pkg.sv
// Shared types and constants for the overwriting ring buffer with JSON framer.
package owrjf_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_JSON  = 2'd2,
    ACT_STATS = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NO_OBJ  = 2'd2,
    STAT_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT,
    S_FAIL
  } fsm_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

>>> sv/owrjf_store.sv
// Byte store: one write port, one read port, registered read data.
module owrjf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/owrjf_scan.sv
// JSON scanner: brace depth, string and escape tracking, one byte a step.
module owrjf_scan #(
  parameter int DW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  owrjf_pkg::scan_ctl_t ctl,
  input  logic [7:0]           ch,
  output logic                 closes
);

  import owrjf_pkg::*;

  logic [DW-1:0] depth, depth_next;
  logic          started, started_next;
  logic          in_str, in_str_next;
  logic          esc, esc_next;

  always_comb begin
    depth_next   = depth;
    started_next = started;
    in_str_next  = in_str;
    esc_next     = esc;
    closes       = 1'b0;
    if (ctl.clear) begin
      depth_next   = '0;
      started_next = 1'b0;
      in_str_next  = 1'b0;
      esc_next     = 1'b0;
    end else if (ctl.step) begin
      if (esc) begin
        esc_next = 1'b0;
      end else if (ch == CH_BSLASH) begin
        esc_next = 1'b1;
      end else if (ch == CH_QUOTE) begin
        in_str_next = !in_str;
      end else if (!in_str) begin
        if (ch == CH_LBRACE) begin
          depth_next   = depth + DW'(1);
          started_next = 1'b1;
        end else if (ch == CH_RBRACE && started) begin
          depth_next = depth - DW'(1);
          closes     = (depth == DW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      started <= 1'b0;
      in_str  <= 1'b0;
      esc     <= 1'b0;
    end else begin
      depth   <= depth_next;
      started <= started_next;
      in_str  <= in_str_next;
      esc     <= esc_next;
    end
  end

endmodule

>>> sv/overwrite_ring_with_json_framer_unit.sv
// Top level: overwriting byte ring buffer with JSON object framer.
// An item is taken only while the controller is idle. A write or a statistics
// reset is done in the execute state, after which the controller is idle again.
// A plain read emits its bytes from the ring; a JSON read first walks the ring
// byte by byte for a closing brace, then emits the object, or reports that no
// object is found. A read with max_count 0, an empty plain read, and a JSON read
// on an empty ring or with max_count 1 are answered from the execute state. The
// byte store has one read port and registered read data: bytes are fetched and
// emitted one per cycle while the output is not stalled. The store has no
// clearing pass after reset; a configuration write restarts the ring.
module overwrite_ring_with_json_framer_unit #(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic        last_of_write,
  input  logic [6:0]  max_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [11:0] bytes_available,
  output logic [31:0] overwrite_events,
  output logic [31:0] overwritten_total
);

  import owrjf_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int SW   = $clog2(DEPTH + 1);
  localparam int CW   = $clog2(MAX_READ + 1);
  localparam int HW   = (PW > CW) ? PW : CW;
  localparam int CMPW = (SW > 13) ? SW : 13;
  localparam int XW   = PW + 12;

  fsm_t          state, state_next;
  action_t       act_q;
  logic [7:0]    data_q;
  logic          lastw_q;
  logic [CW-1:0] maxc_q;

  logic [SW-1:0] buf_size;
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] held, held_next;
  logic [31:0]   ev_cnt, ev_cnt_next;
  logic [31:0]   ovw_cnt, ovw_cnt_next;
  logic          burst, burst_next;
  logic [CW-1:0] byte_cnt, byte_cnt_next;
  logic [PW-1:0] scan_p, scan_p_next;
  logic [CW-1:0] scan_len, scan_len_next;

  logic          in_take;
  logic          slot_free;
  logic          load_out;
  status_t       o_status;
  logic [7:0]    o_byte;
  logic          o_valid;
  logic          o_last;
  logic [PW-1:0] o_held;

  logic          mem_we;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  scan_ctl_t     scan_ctl;
  logic          scan_closes;

  logic [PW-1:0] wp_adv, rp_adv, sp_adv;
  logic          ovw_hit;
  logic          burst_set;
  logic [HW-1:0] held_w, maxc_w, n_w;
  logic [CW-1:0] rd_n;
  logic [CW-1:0] scan_lim;
  logic [CW-1:0] len_n;
  logic [XW-1:0] avail_ext;
  logic [CW-1:0] maxc_eff;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    logic [SW-1:0] q;
    q   = SW'(p) + SW'(1);
    adv = (q >= buf_size) ? '0 : q[PW-1:0];
  endfunction

  owrjf_store #(
    .DEPTH(DEPTH),
    .AW   (PW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wr_ptr),
    .wdata(data_q),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  owrjf_scan #(
    .DW(CW)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .ctl   (scan_ctl),
    .ch    (mem_rdata),
    .closes(scan_closes)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  assign maxc_eff  = (max_count > 7'(MAX_READ)) ? CW'(MAX_READ) : CW'(max_count);

  assign wp_adv    = adv(wr_ptr);
  assign rp_adv    = adv(rd_ptr);
  assign sp_adv    = adv(scan_p);
  assign ovw_hit   = (wp_adv == rd_ptr);
  assign burst_set = burst || ovw_hit;
  assign held_w    = HW'(held);
  assign maxc_w    = HW'(maxc_q);
  assign n_w       = (held_w < maxc_w) ? held_w : maxc_w;
  assign rd_n      = n_w[CW-1:0];
  assign scan_lim  = maxc_q - CW'(1);
  assign len_n     = scan_len + CW'(1);

  always_comb begin
    state_next    = state;
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    held_next     = held;
    ev_cnt_next   = ev_cnt;
    ovw_cnt_next  = ovw_cnt;
    burst_next    = burst;
    byte_cnt_next = byte_cnt;
    scan_p_next   = scan_p;
    scan_len_next = scan_len;
    load_out      = 1'b0;
    o_status      = STAT_OK;
    o_byte        = 8'h00;
    o_valid       = 1'b0;
    o_last        = 1'b1;
    o_held        = held;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr;
    scan_ctl      = '0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_next = S_IDLE;
          case (act_q)
            ACT_WRITE: begin
              mem_we      = 1'b1;
              wr_ptr_next = wp_adv;
              if (ovw_hit) begin
                rd_ptr_next  = rp_adv;
                ovw_cnt_next = ovw_cnt + 32'd1;
              end else begin
                held_next = held + PW'(1);
              end
              if (lastw_q && burst_set) begin
                ev_cnt_next = ev_cnt + 32'd1;
                burst_next  = 1'b0;
              end else begin
                burst_next = burst_set;
              end
              load_out = 1'b1;
              o_held   = held_next;
            end
            ACT_STATS: begin
              ev_cnt_next  = '0;
              ovw_cnt_next = '0;
              load_out     = 1'b1;
            end
            ACT_READ: begin
              if (maxc_q == '0) begin
                load_out = 1'b1;
                o_status = STAT_INVALID;
              end else if (held == '0) begin
                load_out = 1'b1;
                o_status = STAT_EMPTY;
              end else begin
                held_next     = held - PW'(rd_n);
                byte_cnt_next = rd_n;
                mem_re        = 1'b1;
                state_next    = S_EMIT;
              end
            end
            default: begin
              if (maxc_q == '0) begin
                load_out = 1'b1;
                o_status = STAT_INVALID;
              end else if (rd_ptr == wr_ptr || scan_lim == '0) begin
                load_out = 1'b1;
                o_status = STAT_NO_OBJ;
              end else begin
                scan_ctl.clear = 1'b1;
                scan_p_next    = rd_ptr;
                scan_len_next  = '0;
                mem_re         = 1'b1;
                state_next     = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_ctl.step = 1'b1;
        if (scan_closes) begin
          held_next     = held - PW'(len_n);
          byte_cnt_next = len_n;
          mem_re        = 1'b1;
          state_next    = S_EMIT;
        end else if (sp_adv == wr_ptr || len_n >= scan_lim) begin
          state_next = S_FAIL;
        end else begin
          scan_p_next   = sp_adv;
          scan_len_next = len_n;
          mem_re        = 1'b1;
          mem_raddr     = sp_adv;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out      = 1'b1;
          o_byte        = mem_rdata;
          o_valid       = 1'b1;
          o_last        = (byte_cnt == CW'(1));
          rd_ptr_next   = rp_adv;
          byte_cnt_next = byte_cnt - CW'(1);
          if (byte_cnt == CW'(1)) begin
            state_next = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rp_adv;
          end
        end
      end
      S_FAIL: begin
        if (slot_free) begin
          load_out   = 1'b1;
          o_status   = STAT_NO_OBJ;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign avail_ext = XW'(o_held);

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_q   <= action_t'(action);
      data_q  <= data_byte;
      lastw_q <= last_of_write;
      maxc_q  <= maxc_eff;
    end
    if (load_out) begin
      status            <= o_status;
      out_byte          <= o_byte;
      byte_valid        <= o_valid;
      last              <= o_last;
      bytes_available   <= avail_ext[11:0];
      overwrite_events  <= ev_cnt_next;
      overwritten_total <= ovw_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      buf_size  <= SW'(DEPTH);
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      held      <= '0;
      ev_cnt    <= '0;
      ovw_cnt   <= '0;
      burst     <= 1'b0;
      byte_cnt  <= '0;
      scan_p    <= '0;
      scan_len  <= '0;
    end else if (cfg_wr_en) begin
      if (CMPW'(cfg_wr_data) < CMPW'(2)) begin
        buf_size <= SW'(2);
      end else if (CMPW'(cfg_wr_data) > CMPW'(DEPTH)) begin
        buf_size <= SW'(DEPTH);
      end else begin
        buf_size <= SW'(cfg_wr_data);
      end
      wr_ptr <= '0;
      rd_ptr <= '0;
      held   <= '0;
      ev_cnt <= '0;
      ovw_cnt <= '0;
      burst  <= 1'b0;
    end else begin
      state    <= state_next;
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      held     <= held_next;
      ev_cnt   <= ev_cnt_next;
      ovw_cnt  <= ovw_cnt_next;
      burst    <= burst_next;
      byte_cnt <= byte_cnt_next;
      scan_p   <= scan_p_next;
      scan_len <= scan_len_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_held_below_size: assert property (@(posedge clk) disable iff (rst)
    SW'(held) < buf_size)
    else $error("held count not below ring size");

  // held drops on entry to emit, the read pointer catches up byte by byte
  a_empty_iff_equal: assert property (@(posedge clk) disable iff (rst)
    state != S_EMIT |-> ((held == '0) == (rd_ptr == wr_ptr)))
    else $error("held count disagrees with pointers");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (held == '0 && rd_ptr == '0 && wr_ptr == '0))
    else $error("configuration write did not restart ring");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> byte_cnt != '0)
    else $error("emitting with zero byte count");
`endif

endmodule
